// ===== rtl/joint_limit_and_mode_controller_unit_assert.svh =====
// assertion macros for the joint limit and mode controller
`ifndef JOINT_LIMIT_AND_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define JOINT_LIMIT_AND_MODE_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication on clk_i, muted during reset
`define JLMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jlmc assertion failed");

// next-cycle implication on clk_i, muted during reset
`define JLMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jlmc assertion failed");

`else

`define JLMC_ASSERT_NOW(label, ante, cons)
`define JLMC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/jlmc_pkg.sv =====
// types, constants and helpers shared by the joint limit and mode controller
package jlmc_pkg;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  // angles in 1/16 degree
  localparam logic [12:0]        FULL_TURN_U    = 13'd5760;
  localparam logic signed [15:0] FULL_TURN_S16  = 16'sd5760;
  localparam logic signed [16:0] FULL_TURN_S17  = 17'sd5760;
  localparam logic signed [16:0] HALF_TURN_S17  = 17'sd2880;
  localparam logic signed [10:0] DRIVE_POS      = 11'sd500;
  localparam logic signed [10:0] DRIVE_NEG      = -11'sd500;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_IDLE   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_SOFT = 3'd0,
    REG_REV_SOFT = 3'd1,
    REG_FWD_HARD = 3'd2,
    REG_REV_HARD = 3'd3,
    REG_FLAGS    = 3'd4,
    REG_BUTTON   = 3'd5
  } cfg_idx_e;

  localparam int unsigned FLAG_OVR_FWD = 0;
  localparam int unsigned FLAG_OVR_REV = 1;
  localparam int unsigned FLAG_WRAP    = 2;
  localparam int unsigned FLAG_FORCE   = 3;

  typedef struct packed {
    logic [12:0] fwd_soft;
    logic [12:0] rev_soft;
    logic [12:0] fwd_hard;
    logic [12:0] rev_hard;
    logic [3:0]  flags;
    logic [7:0]  button;
  } cfg_t;

  // soft limit writes also reload the effective limits between ticks
  typedef struct packed {
    logic        fwd_vld;
    logic        rev_vld;
    logic [12:0] value;
  } lim_load_t;

  typedef struct packed {
    logic signed [14:0] target;
    mode_e              mode;
    logic [12:0]        fwd_lim;
    logic [12:0]        rev_lim;
  } state_t;

  typedef struct packed {
    logic signed [14:0] motor_angle;
    logic [7:0]         button_code;
    logic               direction;
    logic signed [10:0] open_loop_level;
    logic               target_write;
    logic signed [14:0] target_angle;
    logic               mode_write;
    logic [1:0]         mode_value;
  } in_t;

  typedef struct packed {
    logic               command_kind;
    logic signed [10:0] drive_value;
    logic signed [14:0] setpoint_angle;
    logic               continuous_feedback;
    logic [12:0]        forward_limit_out;
    logic [12:0]        reverse_limit_out;
    mode_e              mode_out;
  } out_t;

  // magnitude of the shortest signed distance from an angle to a limit,
  // taking the way round the circle when the direct way exceeds half a turn
  function automatic logic [16:0] wrap_dist_mag(input logic signed [14:0] from,
                                                input logic [12:0] to);
    logic signed [16:0] d;
    logic signed [16:0] w;
    d = $signed({4'b0000, to}) - $signed({{2{from[14]}}, from});
    if ((d <= HALF_TURN_S17) && (d >= -HALF_TURN_S17)) begin
      w = d;
    end else if (d < 0) begin
      w = d + FULL_TURN_S17;
    end else begin
      w = d - FULL_TURN_S17;
    end
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

endpackage

// ===== rtl/joint_limit_and_mode_controller_unit.sv =====
// top level of the joint limit and mode controller
//
// joint limit and mode controller: each word on the slave stream is one
// control tick. the word lands in an input register, the whole tick
// (target and mode loads, limit overrides, wrap fold, clamp to the safe arc
// by wrapped distance, mode machine) runs as one combinational step against
// the stored target, mode and effective limits, and the answer goes into a
// result register. sustained rate is one word per clock while the sink keeps
// up; a word accepted into the input register moves through the step into
// the result register, which raises m_axis_tvalid. the rate is set by the state
// feedback loop: target, mode and limits of one tick feed the next, so the
// step is closed combinationally. the result register lets a new word enter
// while a finished one waits on m_axis_tready; s_axis_tready only drops when
// both registers hold words and the sink stalls. configuration writes are
// always taken (cfg_ready_o high) and are meant for idle periods; a write to
// either soft limit reloads its effective limit unless a tick advances alongside.
module joint_limit_and_mode_controller_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // motor_angle, button_code, direction, open_loop_level, target_write,
  // target_angle, mode_write, mode_value, zero pad
  input  logic [jlmc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // master stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // drive_value, setpoint_angle, continuous_feedback, forward_limit_out,
  // reverse_limit_out, mode_out, zero pad
  output logic [jlmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // command_kind
  output logic                                 m_axis_tuser,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jlmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [jlmc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import jlmc_pkg::*;

  cfg_t      cfg;
  lim_load_t load;
  in_t       in_word;
  in_t       in_q;
  logic      in_valid_q, in_valid_d;
  out_t      out_q;
  out_t      step_res;
  logic      out_valid_q, out_valid_d;
  state_t    st_q, st_d, step_st;
  logic      advance;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  jlmc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg),
    .load_o    (load)
  );

  // unpack the slave word, first field in the low bits
  assign in_word.motor_angle     = $signed(s_axis_tdata[14:0]);
  assign in_word.button_code     = s_axis_tdata[22:15];
  assign in_word.direction       = s_axis_tdata[23];
  assign in_word.open_loop_level = $signed(s_axis_tdata[34:24]);
  assign in_word.target_write    = s_axis_tdata[35];
  assign in_word.target_angle    = $signed(s_axis_tdata[50:36]);
  assign in_word.mode_write      = s_axis_tdata[51];
  assign in_word.mode_value      = s_axis_tdata[53:52];

  // a held word moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign in_valid_d  = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  jlmc_step u_step (
    .in_i  (in_q),
    .cfg_i (cfg),
    .st_i  (st_q),
    .st_o  (step_st),
    .res_o (step_res)
  );

  // the tick owns the state; soft limit writes reload it between ticks
  always_comb begin
    st_d = st_q;
    if (advance) begin
      st_d = step_st;
    end else begin
      if (load.fwd_vld) begin
        st_d.fwd_lim = load.value;
      end
      if (load.rev_vld) begin
        st_d.rev_lim = load.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.target  <= '0;
      st_q.mode    <= MODE_CLOSED;
      st_q.fwd_lim <= FULL_TURN_U;
      st_q.rev_lim <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_word;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  // pack the master word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.command_kind;
  assign m_axis_tdata  = {1'b0,
                          out_q.mode_out,
                          out_q.reverse_limit_out,
                          out_q.forward_limit_out,
                          out_q.continuous_feedback,
                          out_q.setpoint_angle,
                          out_q.drive_value};

`include "joint_limit_and_mode_controller_unit_assert.svh"

  `JLMC_ASSERT_NEXT(a_result_follows, in_valid_q && advance, out_valid_q)
  `JLMC_ASSERT_NOW(a_setpoint_no_drive, m_axis_tvalid && m_axis_tuser, out_q.drive_value == '0)
  `JLMC_ASSERT_NOW(a_setpoint_closed, m_axis_tvalid && m_axis_tuser, out_q.mode_out == MODE_CLOSED)
  `JLMC_ASSERT_NOW(a_stall_cause, !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready)

endmodule

// ===== rtl/jlmc_cfg_regs.sv =====
// configuration register file with soft limit reload events
module jlmc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [jlmc_pkg::CFG_IDX_W-1:0]      wr_idx_i,
  input  logic [jlmc_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output jlmc_pkg::cfg_t                      cfg_o,
  output jlmc_pkg::lim_load_t                 load_o
);
  import jlmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d          = cfg_q;
    load_o.fwd_vld = 1'b0;
    load_o.rev_vld = 1'b0;
    load_o.value   = wr_data_i;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        REG_FWD_SOFT: begin
          cfg_d.fwd_soft = wr_data_i;
          load_o.fwd_vld = 1'b1;
        end
        REG_REV_SOFT: begin
          cfg_d.rev_soft = wr_data_i;
          load_o.rev_vld = 1'b1;
        end
        REG_FWD_HARD: cfg_d.fwd_hard = wr_data_i;
        REG_REV_HARD: cfg_d.rev_hard = wr_data_i;
        REG_FLAGS:    cfg_d.flags    = wr_data_i[3:0];
        REG_BUTTON:   cfg_d.button   = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_soft <= FULL_TURN_U;
      cfg_q.rev_soft <= '0;
      cfg_q.fwd_hard <= FULL_TURN_U;
      cfg_q.rev_hard <= '0;
      cfg_q.flags    <= '0;
      cfg_q.button   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/jlmc_step.sv =====
// one control tick: overrides, wrap fold, limit clamp and mode machine
module jlmc_step (
  input  jlmc_pkg::in_t    in_i,
  input  jlmc_pkg::cfg_t   cfg_i,
  input  jlmc_pkg::state_t st_i,
  output jlmc_pkg::state_t st_o,
  output jlmc_pkg::out_t   res_o
);
  import jlmc_pkg::*;

  logic               ovf, ovr, wrap, force_open;
  logic signed [14:0] t1, t2, t3;
  logic signed [15:0] t1_ext, fold_sum, t2_ext, f2_ext, r2_ext;
  mode_e              m1, m2;
  logic [12:0]        f1, r1, f2, r2;
  logic               safe;
  logic [16:0]        df_mag, dr_mag;

  assign ovf        = cfg_i.flags[FLAG_OVR_FWD];
  assign ovr        = cfg_i.flags[FLAG_OVR_REV];
  assign wrap       = cfg_i.flags[FLAG_WRAP];
  assign force_open = cfg_i.flags[FLAG_FORCE];

  // target and mode loads ahead of the tick, mode code three reads as idle
  assign t1 = in_i.target_write ? in_i.target_angle : st_i.target;
  always_comb begin
    m1 = st_i.mode;
    if (in_i.mode_write) begin
      m1 = (in_i.mode_value == 2'd3) ? MODE_IDLE : mode_e'(in_i.mode_value);
    end
  end

  assign f1 = ovf ? cfg_i.fwd_hard : st_i.fwd_lim;
  assign r1 = ovr ? cfg_i.rev_hard : st_i.rev_lim;

  // single fold: one turn is added below 0 or taken off above 360 degrees
  assign t1_ext   = {t1[14], t1};
  assign fold_sum = (t1 < 0) ? (t1_ext + FULL_TURN_S16) : (t1_ext - FULL_TURN_S16);

  always_comb begin
    t2 = t1;
    f2 = f1;
    r2 = r1;
    if (wrap) begin
      if ((t1 < 0) || (t1_ext > FULL_TURN_S16)) begin
        t2 = fold_sum[14:0];
      end
      if (ovf || ovr) begin
        f2 = '0;
        r2 = '0;
      end else begin
        f2 = cfg_i.fwd_hard;
        r2 = cfg_i.rev_hard;
      end
    end
  end

  // safe arc test, equal limits leave every angle safe
  assign t2_ext = {t2[14], t2};
  assign f2_ext = $signed({3'b000, f2});
  assign r2_ext = $signed({3'b000, r2});

  always_comb begin
    if (f2 > r2) begin
      safe = (t2_ext < f2_ext) && (t2_ext > r2_ext);
    end else if (f2 < r2) begin
      safe = (t2_ext < f2_ext) || (t2_ext > r2_ext);
    end else begin
      safe = 1'b1;
    end
  end

  assign df_mag = wrap_dist_mag(t2, f2);
  assign dr_mag = wrap_dist_mag(t2, r2);

  // a tie goes to the reverse limit
  always_comb begin
    t3 = t2;
    if (!safe) begin
      t3 = (df_mag < dr_mag) ? $signed({2'b00, f2}) : $signed({2'b00, r2});
    end
  end

  assign m2 = force_open ? MODE_OPEN : m1;

  always_comb begin
    st_o.target    = t3;
    st_o.mode      = m2;
    st_o.fwd_lim   = f2;
    st_o.rev_lim   = r2;
    res_o.command_kind        = 1'b0;
    res_o.drive_value         = '0;
    res_o.setpoint_angle      = '0;
    res_o.continuous_feedback = wrap;
    res_o.forward_limit_out   = f1;
    res_o.reverse_limit_out   = r1;
    if (in_i.button_code == cfg_i.button) begin
      st_o.mode         = MODE_OPEN;
      res_o.drive_value = in_i.direction ? DRIVE_POS : DRIVE_NEG;
    end else if (m2 == MODE_CLOSED) begin
      res_o.command_kind   = 1'b1;
      res_o.setpoint_angle = t3;
    end else if (m2 == MODE_OPEN) begin
      if (in_i.open_loop_level == '0) begin
        st_o.mode   = MODE_CLOSED;
        st_o.target = in_i.motor_angle;
      end else begin
        res_o.drive_value = in_i.open_loop_level;
      end
    end
    res_o.mode_out = st_o.mode;
  end

endmodule

// ===== tb/sv/jlmc_result_checker.sv =====
// result checker for the joint limit and mode controller: mirrors config, predicts and compares
module jlmc_result_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic                             s_ready_i,
  input  logic [jlmc_pkg::IN_TDATA_W-1:0]  s_data_i,
  input  logic                             m_valid_i,
  input  logic                             m_ready_i,
  input  logic [jlmc_pkg::OUT_TDATA_W-1:0] m_data_i,
  input  logic                             m_user_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [jlmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jlmc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);
  import jlmc_pkg::*;

  localparam int TURN = 5760;
  localparam int HALF = 2880;
  localparam int PRINT_CAP = 100;

  // register mirror
  logic [12:0] soft_fwd, soft_rev, hard_fwd, hard_rev;
  logic [3:0]  flags;
  logic [7:0]  manual_button;

  // controller state mirror
  int    target_pos;
  mode_e mode_st;
  int    fwd_lim, rev_lim;

  out_t  result_q[$];
  in_t   tick_in;
  out_t  seen, want;

  task automatic report_mismatch(string what, int got, int exp_val);
    if (mismatches_o < PRINT_CAP) begin
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp_val);
    end
    mismatches_o++;
  endtask

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // signed way round the circle from an angle to a limit
  function automatic int arc_offset(int from, int to);
    if (mag(to - from) <= HALF) return to - from;
    if (from > to) return (TURN - from) + to;
    return -((TURN - to) + from);
  endfunction

  function automatic out_t run_tick(in_t w);
    out_t r;
    bit   outside;
    int   df, dr;
    r = '0;
    if (w.target_write) target_pos = int'(w.target_angle);
    if (w.mode_write) begin
      mode_st = (w.mode_value == 2'd3) ? MODE_IDLE : mode_e'(w.mode_value);
    end
    if (flags[FLAG_OVR_FWD]) fwd_lim = int'(hard_fwd);
    if (flags[FLAG_OVR_REV]) rev_lim = int'(hard_rev);
    // reported limits are taken before the wrap reload
    r.forward_limit_out = fwd_lim[12:0];
    r.reverse_limit_out = rev_lim[12:0];
    if (flags[FLAG_WRAP]) begin
      if (target_pos < 0) target_pos += TURN;
      else if (target_pos > TURN) target_pos -= TURN;
      if (flags[FLAG_OVR_FWD] || flags[FLAG_OVR_REV]) begin
        fwd_lim = 0;
        rev_lim = 0;
      end else begin
        fwd_lim = int'(hard_fwd);
        rev_lim = int'(hard_rev);
      end
    end
    if (fwd_lim > rev_lim) outside = !(target_pos < fwd_lim && target_pos > rev_lim);
    else if (fwd_lim < rev_lim) outside = !(target_pos < fwd_lim || target_pos > rev_lim);
    else outside = 1'b0;
    if (outside) begin
      df = arc_offset(target_pos, fwd_lim);
      dr = arc_offset(target_pos, rev_lim);
      target_pos = (mag(df) < mag(dr)) ? fwd_lim : rev_lim;
    end
    if (flags[FLAG_FORCE]) mode_st = MODE_OPEN;
    if (w.button_code == manual_button) begin
      mode_st = MODE_OPEN;
      r.drive_value = w.direction ? DRIVE_POS : DRIVE_NEG;
    end else if (mode_st == MODE_CLOSED) begin
      r.command_kind   = 1'b1;
      r.setpoint_angle = target_pos[14:0];
    end else if (mode_st == MODE_OPEN) begin
      if (w.open_loop_level == 0) begin
        mode_st    = MODE_CLOSED;
        target_pos = int'(w.motor_angle);
      end else begin
        r.drive_value = w.open_loop_level;
      end
    end
    r.continuous_feedback = flags[FLAG_WRAP];
    r.mode_out = mode_st;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      soft_fwd      = 13'd5760;
      soft_rev      = 13'd0;
      hard_fwd      = 13'd5760;
      hard_rev      = 13'd0;
      flags         = 4'd0;
      manual_button = 8'd0;
      target_pos    = 0;
      mode_st       = MODE_CLOSED;
      fwd_lim       = 5760;
      rev_lim       = 0;
      result_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_FWD_SOFT: begin
            soft_fwd = cfg_data_i;
            fwd_lim  = int'(cfg_data_i);
          end
          REG_REV_SOFT: begin
            soft_rev = cfg_data_i;
            rev_lim  = int'(cfg_data_i);
          end
          REG_FWD_HARD: hard_fwd = cfg_data_i;
          REG_REV_HARD: hard_rev = cfg_data_i;
          REG_FLAGS:    flags = cfg_data_i[3:0];
          REG_BUTTON:   manual_button = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        tick_in.motor_angle     = s_data_i[14:0];
        tick_in.button_code     = s_data_i[22:15];
        tick_in.direction       = s_data_i[23];
        tick_in.open_loop_level = s_data_i[34:24];
        tick_in.target_write    = s_data_i[35];
        tick_in.target_angle    = s_data_i[50:36];
        tick_in.mode_write      = s_data_i[51];
        tick_in.mode_value      = s_data_i[53:52];
        result_q.push_back(run_tick(tick_in));
      end
      if (m_valid_i && m_ready_i) begin
        seen.command_kind        = m_user_i;
        seen.drive_value         = m_data_i[10:0];
        seen.setpoint_angle      = m_data_i[25:11];
        seen.continuous_feedback = m_data_i[26];
        seen.forward_limit_out   = m_data_i[39:27];
        seen.reverse_limit_out   = m_data_i[52:40];
        seen.mode_out            = mode_e'(m_data_i[54:53]);
        if (result_q.size() == 0) begin
          report_mismatch("result with no tick pending", int'(seen.command_kind), 0);
        end else begin
          want = result_q.pop_front();
          if (seen.command_kind !== want.command_kind)
            report_mismatch("command_kind", int'(seen.command_kind), int'(want.command_kind));
          if (seen.drive_value !== want.drive_value)
            report_mismatch("drive_value", int'(seen.drive_value), int'(want.drive_value));
          if (seen.setpoint_angle !== want.setpoint_angle)
            report_mismatch("setpoint_angle", int'(seen.setpoint_angle),
                            int'(want.setpoint_angle));
          if (seen.continuous_feedback !== want.continuous_feedback)
            report_mismatch("continuous_feedback", int'(seen.continuous_feedback),
                            int'(want.continuous_feedback));
          if (seen.forward_limit_out !== want.forward_limit_out)
            report_mismatch("forward_limit_out", int'(seen.forward_limit_out),
                            int'(want.forward_limit_out));
          if (seen.reverse_limit_out !== want.reverse_limit_out)
            report_mismatch("reverse_limit_out", int'(seen.reverse_limit_out),
                            int'(want.reverse_limit_out));
          if (seen.mode_out !== want.mode_out)
            report_mismatch("mode_out", int'(seen.mode_out), int'(want.mode_out));
        end
      end
    end
    outstanding_o = result_q.size();
  end

endmodule

// ===== tb/sv/tb_joint_limit_and_mode_controller_unit.sv =====
// testbench top for the joint limit and mode controller: stimulus, sink pacing and verdict
module tb_joint_limit_and_mode_controller_unit;
  import jlmc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;     // margin for the last result to drain
  localparam int SINK_HOLD    = 80;    // long sink stall, well past the two word buffer
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_TICKS  = 200;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int mismatches;
  int outstanding;
  int cycle_count;

  // pacing knobs shared between the source and the sink
  bit quiet;       // final stretch, no idling on either side
  bit hold_sink;   // request one long sink stall
  int gap_pct;     // chance of a source gap before a word

  joint_limit_and_mode_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  jlmc_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, sized from the slowest legal pacing many times over
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // sink pacing: random stall bursts, one long hold on request, none when quiet
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_sink && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (SINK_HOLD) @(negedge clk_i);
        hold_done     = 1'b1;
        m_axis_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // one register write; the channel is always ready but the handshake is honored
  task automatic write_reg(cfg_idx_e idx, logic [12:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // full register set; upper data bits of the narrow registers carry noise
  task automatic load_config(logic [12:0] fs, logic [12:0] rs, logic [12:0] fh,
                             logic [12:0] rh, logic [3:0] fl, logic [7:0] btn);
    write_reg(REG_FWD_HARD, fh);
    write_reg(REG_REV_HARD, rh);
    write_reg(REG_FLAGS, {9'($urandom), fl});
    write_reg(REG_BUTTON, {5'($urandom), btn});
    write_reg(REG_FWD_SOFT, fs);
    write_reg(REG_REV_SOFT, rs);
  endtask

  // drive one tick word, with an optional idle burst ahead of it
  task automatic send_tick(in_t w);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, w.mode_value, w.mode_write, w.target_angle, w.target_write,
                     w.open_loop_level, w.direction, w.button_code, w.motor_angle};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // source goes quiet until every result is back, then the pipe drains
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic in_t make_tick(int motor, int btn, int dir, int level,
                                    int tw, int tgt, int mw, int mv);
    in_t w;
    w.motor_angle     = 15'(motor);
    w.button_code     = 8'(btn);
    w.direction       = 1'(dir);
    w.open_loop_level = 11'(level);
    w.target_write    = 1'(tw);
    w.target_angle    = 15'(tgt);
    w.mode_write      = 1'(mw);
    w.mode_value      = 2'(mv);
    return w;
  endfunction

  // angle: mostly within two turns either way, sometimes the full field
  function automatic logic [14:0] rand_angle();
    if ($urandom_range(0, 3) == 0) return 15'($urandom);
    return 15'(int'($urandom_range(0, 23040)) - 11520);
  endfunction

  function automatic logic [12:0] rand_limit();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return 13'd5760;
      2:       return 13'd8191;
      default: return 13'($urandom_range(0, 5760));
    endcase
  endfunction

  function automatic in_t random_tick(logic [7:0] btn);
    in_t w;
    w.motor_angle  = rand_angle();
    w.button_code  = ($urandom_range(0, 4) == 0) ? btn : 8'($urandom);
    w.direction    = 1'($urandom);
    case ($urandom_range(0, 7))
      0, 1:    w.open_loop_level = 11'sd0;
      2:       w.open_loop_level = 11'($urandom);
      default: w.open_loop_level = 11'(int'($urandom_range(0, 2000)) - 1000);
    endcase
    w.target_write = 1'($urandom);
    w.target_angle = rand_angle();
    w.mode_write   = ($urandom_range(0, 3) == 0);
    w.mode_value   = 2'($urandom);
    return w;
  endfunction

  initial begin
    logic [3:0] fl;
    logic [7:0] btn;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FWD_SOFT;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    hold_sink     = 1'b0;
    gap_pct       = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: plain arc 0..360, manual button 0xa5
    load_config(13'd5760, 13'd0, 13'd5760, 13'd0, 4'b0000, 8'hA5);
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 100, 1, 0));          // closed loop setpoint
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, -16384, 0, 0));       // most negative target clamps
    send_tick(make_tick(0, 8'h00, 1, 0, 1, 16383, 0, 0));        // most positive target clamps
    send_tick(make_tick(0, 8'h5A, 0, 1023, 0, 0, 1, 1));         // open loop, top level passes
    send_tick(make_tick(0, 8'hFF, 0, -1024, 0, 0, 0, 0));        // bottom level passes
    send_tick(make_tick(-16384, 8'hFF, 1, 0, 0, 0, 0, 0));       // zero level falls back
    send_tick(make_tick(16383, 8'hFF, 1, 0, 0, 0, 0, 0));        // closed with motor target
    send_tick(make_tick(0, 8'hFF, 0, 0, 0, 0, 1, 2));            // idle drives zero
    send_tick(make_tick(0, 8'hFF, 0, 500, 0, 0, 1, 3));          // mode three stored as idle
    send_tick(make_tick(0, 8'hA5, 1, 0, 0, 0, 0, 0));            // manual button, positive
    send_tick(make_tick(0, 8'hA5, 0, 0, 0, 0, 0, 0));            // manual button, negative
    send_tick(make_tick(16383, 8'hFF, 0, 0, 0, 0, 0, 0));        // open, zero level
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 2880, 0, 0));         // half turn in the arc
    settle();

    // equal soft limits: nothing is clamped
    load_config(13'd1000, 13'd1000, 13'd5760, 13'd0, 4'b0000, 8'h00);
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, -16384, 1, 0));
    send_tick(make_tick(0, 8'hFF, 1, 0, 1, 16383, 0, 0));
    settle();

    // wrap without overrides: hard limits 1000..4000, fold and tie to reverse
    load_config(13'd5760, 13'd0, 13'd4000, 13'd1000, 4'b0100, 8'h3C);
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, -100, 1, 0));
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 6000, 0, 0));
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 5380, 0, 0));        // equally far from both
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 5761, 0, 0));
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 5760, 0, 0));
    settle();

    // every flag set: wrap with overrides zeroes the limits, force open
    load_config(13'd3000, 13'd2000, 13'd8191, 13'd0, 4'b1111, 8'hFF);
    send_tick(make_tick(100, 8'h00, 0, 700, 1, -50, 0, 0));
    send_tick(make_tick(200, 8'h00, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 8'hFF, 1, 0, 0, 0, 0, 0));
    settle();

    // reverse override only, inverted arc
    load_config(13'd0, 13'd8191, 13'd2000, 13'd6000, 4'b0010, 8'h00);
    send_tick(make_tick(0, 8'hFF, 0, 0, 1, 3000, 1, 0));
    send_tick(make_tick(0, 8'hFF, 1, 0, 1, -200, 0, 0));
    settle();

    // random phases, each with its own register set and pacing
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiet   = (ph == RAND_PHASES - 1);
      gap_pct = quiet ? 0 : ((ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 35));
      fl      = (ph == 0) ? 4'd0 : ((ph == 1) ? 4'd15 : 4'($urandom));
      btn     = (ph == 0) ? 8'h00 : ((ph == 1) ? 8'hFF : 8'($urandom));
      load_config(rand_limit(), rand_limit(), rand_limit(), rand_limit(), fl, btn);
      // long sink hold while the source keeps pushing, so input backpressure shows
      if (ph == 2) hold_sink = 1'b1;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // source pause until the pipe is empty, mid phase
        if (ph == 4 && n == PHASE_TICKS / 2) begin
          s_axis_tvalid = 1'b0;
          while (outstanding != 0) @(negedge clk_i);
        end
        send_tick(random_tick(btn));
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
